### rtl/core/ccpa_pkg.sv
// Shared types and constants of the chunk pool allocator.
package ccpa_pkg;
    localparam int MAX_CHUNKS = 1024;
    localparam int IDX_W      = $clog2(MAX_CHUNKS);
    localparam int POOL_W     = 11;
    localparam int CHUNK_W    = 17;
    localparam int SIZE_W     = 27;
    localparam int OFF_W      = 26;
    localparam int BYTE_W     = 27;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CHUNK_W-1:0] CHUNK_MAX   = CHUNK_W'(65536);
    localparam logic [CHUNK_W-1:0] CHUNK_RESET = CHUNK_W'(64);
    localparam logic [POOL_W-1:0]  POOL_RESET  = POOL_W'(1024);
    localparam logic [POOL_W-1:0]  POOL_MAX    = POOL_W'(MAX_CHUNKS);

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_NOSPACE      = 3'd1,
        ST_OUTSIDE      = 3'd2,
        ST_MISALIGNED   = 3'd3,
        ST_ALREADY_FREE = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        CFG_CHUNK_SIZE  = 2'd0,
        CFG_POOL_CHUNKS = 2'd1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE
    } t_state;

    typedef struct packed {
        logic shift;
        logic head_in;
    } t_ring_ctl;
endpackage

### rtl/core/contiguous_chunk_pool_allocator.sv
// Top level: chunk pool allocator built on a rotating ring of free-mark cells.
//
// Usage:
//   Command channel: drive i_mode, i_size_bytes, i_release_offset and raise
//   start; the transaction is taken on a clock edge where busy is low.
//   mode 0 allocates the lowest contiguous run of free chunks covering the
//   byte size; mode 1 releases a run at a byte offset.
//   Result: o_valid is high for exactly one cycle with o_status and
//   o_grant_offset. The receiver cannot stall; it must sample that cycle.
//   Configuration: i_cfg_we with i_cfg_idx (0 chunk size, 1 pool chunks)
//   and i_cfg_data, written in one cycle, only while busy is low.
// Timing:
//   The free map lives in a ring of MAX_CHUNKS cells that rotates by one
//   each cycle in scan and update, not while idle; the controller then sees
//   one chunk per cycle at the ring head. Success: a scan and an update rotation;
//   no space or a rejected free found by the scan: the scan rotation only.
//   Zero-size allocate or offset past the pool end: the cycle after acceptance.
//   No division is used: byte positions accumulate the chunk size per step.
// Reset:
//   Synchronous, active low; all chunks free, chunk size 64, pool 1024.
module contiguous_chunk_pool_allocator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_mode,
    input  logic [ccpa_pkg::SIZE_W-1:0]       i_size_bytes,
    input  logic [ccpa_pkg::OFF_W-1:0]        i_release_offset,
    input  logic                              i_cfg_we,
    input  logic [ccpa_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ccpa_pkg::CHUNK_W-1:0]      i_cfg_data,
    output logic                              o_valid,
    output logic [2:0]                        o_status,
    output logic [ccpa_pkg::OFF_W-1:0]        o_grant_offset
);
    import ccpa_pkg::*;

    // configuration registers, raw bits as written
    logic [CHUNK_W-1:0] r_chunk;
    logic [POOL_W-1:0]  r_pool;

    t_state r_state, n_state;
    logic [IDX_W-1:0]  r_cnt, n_cnt;
    logic              r_mode;
    logic [SIZE_W-1:0] r_size;
    logic [OFF_W-1:0]  r_off;
    logic [CHUNK_W-1:0] r_c;
    logic [POOL_W-1:0]  r_p;
    logic [BYTE_W-1:0]  r_pb;
    logic [BYTE_W-1:0]  r_pos, n_pos;
    logic [BYTE_W-1:0]  r_run, n_run;      // bytes covered by current run / range
    logic [IDX_W-1:0]   r_st_idx, n_st_idx;
    logic [BYTE_W-1:0]  r_st_pos, n_st_pos;
    logic               r_found, n_found;  // alloc run found / free offset matched
    logic               r_afree, n_afree;
    logic               r_valid, n_valid;
    t_status            r_status, n_status;
    logic [OFF_W-1:0]   r_grant, n_grant;

    logic [CHUNK_W-1:0] eff_c;
    logic [POOL_W-1:0]  eff_p;
    logic [BYTE_W-1:0]  pool_bytes;
    logic [BYTE_W-1:0]  run_next;
    logic               active, in_range, last, match;
    t_ring_ctl          ring;
    logic [MAX_CHUNKS-1:0] marks;

    // ring of cells: cell k takes from cell k+1, head feeds back to the tail
    genvar g;
    generate
        for (g = 0; g < MAX_CHUNKS; g++) begin : g_cell
            if (g == MAX_CHUNKS - 1) begin : g_tail
                ccpa_cell u_cell (
                    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_shift(ring.shift),
                    .i_d(ring.head_in), .o_q(marks[g])
                );
            end else begin : g_body
                ccpa_cell u_cell (
                    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_shift(ring.shift),
                    .i_d(marks[g+1]), .o_q(marks[g])
                );
            end
        end
    endgenerate

    // saturated views of the config registers
    always_comb begin
        eff_c = r_chunk;
        if (r_chunk == '0) eff_c = CHUNK_W'(1);
        else if (r_chunk > CHUNK_MAX) eff_c = CHUNK_MAX;
        eff_p = r_pool;
        if (r_pool == '0) eff_p = POOL_W'(1);
        else if (r_pool > POOL_MAX) eff_p = POOL_MAX;
    end

    assign pool_bytes = BYTE_W'(eff_p * eff_c);
    assign busy       = (r_state != S_IDLE);
    assign active     = ({1'b0, r_cnt} < r_p);
    assign last       = (r_cnt == IDX_W'(MAX_CHUNKS - 1));
    assign match      = active && (r_pos == BYTE_W'(r_off));
    assign run_next   = r_run + BYTE_W'(r_c);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk <= CHUNK_RESET;
            r_pool  <= POOL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CHUNK_SIZE:  r_chunk <= i_cfg_data;
                CFG_POOL_CHUNKS: r_pool  <= i_cfg_data[POOL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt    <= n_cnt;
        r_pos    <= n_pos;
        r_run    <= n_run;
        r_st_idx <= n_st_idx;
        r_st_pos <= n_st_pos;
        r_found  <= n_found;
        r_afree  <= n_afree;
        r_status <= n_status;
        r_grant  <= n_grant;
        if (start && !busy) begin
            r_mode <= i_mode;
            r_size <= i_size_bytes;
            r_off  <= i_release_offset;
            r_c    <= eff_c;
            r_p    <= eff_p;
            r_pb   <= pool_bytes;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_pos    = r_pos;
        n_run    = r_run;
        n_st_idx = r_st_idx;
        n_st_pos = r_st_pos;
        n_found  = r_found;
        n_afree  = r_afree;
        n_status = r_status;
        n_grant  = r_grant;
        n_valid  = 1'b0;
        in_range = 1'b0;
        ring.shift   = 1'b0;
        ring.head_in = marks[0];

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cnt   = '0;
                    n_pos   = '0;
                    n_run   = '0;
                    n_found = 1'b0;
                    n_afree = 1'b0;
                    n_grant = '0;
                    if (!i_mode && i_size_bytes == '0) begin
                        n_status = ST_NOSPACE;
                        n_valid  = 1'b1;
                    end else if (i_mode && BYTE_W'(i_release_offset) >= pool_bytes) begin
                        n_status = ST_OUTSIDE;
                        n_valid  = 1'b1;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                ring.shift = 1'b1;
                n_cnt = r_cnt + 1'b1;
                n_pos = r_pos + BYTE_W'(r_c);
                if (!r_mode) begin
                    // first fit: grow run over free chunks, reset on a used one
                    if (!r_found && active) begin
                        if (marks[0]) begin
                            if (r_run == '0) begin
                                n_st_idx = r_cnt;
                                n_st_pos = r_pos;
                            end
                            n_run = run_next;
                            if (run_next >= BYTE_W'(r_size)) n_found = 1'b1;
                        end else begin
                            n_run = '0;
                        end
                    end
                end else begin
                    if (match && !r_found) begin
                        n_found  = 1'b1;
                        n_st_idx = r_cnt;
                    end
                    in_range = (match || r_found) && (r_run < BYTE_W'(r_size));
                    if (in_range) begin
                        n_run = run_next;
                        if (marks[0]) n_afree = 1'b1;
                    end
                end
                if (last) begin
                    n_run = '0;
                    if (!r_mode) begin
                        if (n_found) begin
                            n_state = S_UPDATE;
                        end else begin
                            n_state  = S_IDLE;
                            n_status = ST_NOSPACE;
                            n_valid  = 1'b1;
                        end
                    end else if (!n_found) begin
                        n_state  = S_IDLE;
                        n_status = ST_MISALIGNED;
                        n_valid  = 1'b1;
                    end else if ({1'b0, BYTE_W'(r_off)} + {1'b0, r_size} > {1'b0, r_pb}) begin
                        // one extra bit: offset plus size can exceed the byte width
                        n_state  = S_IDLE;
                        n_status = ST_OUTSIDE;
                        n_valid  = 1'b1;
                    end else if (n_afree) begin
                        n_state  = S_IDLE;
                        n_status = ST_ALREADY_FREE;
                        n_valid  = 1'b1;
                    end else begin
                        n_state = S_UPDATE;
                    end
                end
            end
            S_UPDATE: begin
                // second rotation rewrites the marks of the run
                ring.shift = 1'b1;
                n_cnt = r_cnt + 1'b1;
                in_range = (r_cnt >= r_st_idx) && (r_run < BYTE_W'(r_size));
                if (in_range) begin
                    n_run = run_next;
                    ring.head_in = r_mode;
                end
                if (last) begin
                    n_state  = S_IDLE;
                    n_status = ST_OK;
                    n_grant  = r_mode ? '0 : r_st_pos[OFF_W-1:0];
                    n_valid  = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_grant_offset = r_grant;

    a_quiet_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !start) |=> !o_valid)
        else $error("result strobe without a transaction");
    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_grant_offset != '0) |-> (o_status == ST_OK))
        else $error("grant offset on failed transaction");
    a_idle_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("result while still busy");
    a_no_shift_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !ring.shift) else $error("ring moved while idle");
endmodule

### rtl/core/ccpa_cell.sv
// One free-mark cell of the rotating chunk ring.
module ccpa_cell (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_shift,
    input  logic i_d,
    output logic o_q
);
    logic r_mark;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark <= 1'b1;
        end else if (i_shift) begin
            r_mark <= i_d;
        end
    end

    assign o_q = r_mark;
endmodule

### tb/sv/contiguous_chunk_pool_allocator_test.sv
// Self-checking testbench for the contiguous chunk pool allocator.
`timescale 1ns / 1ps

module contiguous_chunk_pool_allocator_test;
    import ccpa_pkg::*;

    // One allocator answer: status and granted byte offset.
    typedef struct {
        t_status          status;
        logic [OFF_W-1:0] grant;
    } t_answer;

    // Live grant held by the stimulus so it can be handed back later.
    typedef struct {
        longint offset;
        longint size;
    } t_region;

    // ------------------------------------------------------------------
    // Scoreboard: keeps a shadow free map and the configuration, predicts
    // every accepted transaction and matches answers in order.
    // ------------------------------------------------------------------
    class alloc_scoreboard;
        bit               free_mark[MAX_CHUNKS];
        logic [CHUNK_W-1:0] chunk_reg;
        logic [POOL_W-1:0]  pool_reg;
        t_answer          pending_answers[$];
        int               mismatches;

        function void clear();
            foreach (free_mark[i]) free_mark[i] = 1'b1;
            chunk_reg = CHUNK_RESET;
            pool_reg  = POOL_RESET;
            pending_answers.delete();
            mismatches = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CHUNK_W-1:0] data);
            if (idx == CFG_CHUNK_SIZE) chunk_reg = data;
            else if (idx == CFG_POOL_CHUNKS) pool_reg = data[POOL_W-1:0];
        endfunction

        function longint granule();
            longint c;
            c = chunk_reg;
            if (c < 1) c = 1;
            if (c > 65536) c = 65536;
            return c;
        endfunction

        function longint pool_len();
            longint p;
            p = pool_reg;
            if (p < 1) p = 1;
            if (p > MAX_CHUNKS) p = MAX_CHUNKS;
            return p;
        endfunction

        // Work out the answer of an accepted transaction, update the map,
        // queue the answer and return it to the stimulus side.
        function t_answer note_accepted(logic mode, longint size, longint off);
            longint  c, p, n, run, first, i;
            bit      found;
            t_answer a;
            c = granule();
            p = pool_len();
            n = (size + c - 1) / c;
            a.status = ST_OK;
            a.grant  = '0;
            found    = 1'b0;
            first    = 0;
            if (mode == 1'b0) begin
                run = 0;
                if (n != 0 && n <= p) begin
                    for (i = 0; i < p && !found; i++) begin
                        if (free_mark[i]) begin
                            run++;
                            if (run == n) begin
                                first = i + 1 - n;
                                found = 1'b1;
                            end
                        end else begin
                            run = 0;
                        end
                    end
                end
                if (found) begin
                    for (i = first; i < first + n; i++) free_mark[i] = 1'b0;
                    a.grant = OFF_W'(first * c);
                end else begin
                    a.status = ST_NOSPACE;
                end
            end else begin
                if (off >= p * c) begin
                    a.status = ST_OUTSIDE;
                end else if (off % c != 0) begin
                    a.status = ST_MISALIGNED;
                end else begin
                    first = off / c;
                    if (n > p - first) begin
                        a.status = ST_OUTSIDE;
                    end else begin
                        for (i = first; i < first + n; i++)
                            if (free_mark[i]) a.status = ST_ALREADY_FREE;
                        if (a.status == ST_OK)
                            for (i = first; i < first + n; i++) free_mark[i] = 1'b1;
                    end
                end
            end
            pending_answers.insert(pending_answers.size(), a);
            return a;
        endfunction

        function void check_answer(logic [2:0] status, logic [OFF_W-1:0] grant);
            t_answer a;
            if (pending_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected answer: status %0d grant 0x%0h", status, grant);
                return;
            end
            a = pending_answers.pop_front();
            if (status !== a.status || grant !== a.grant) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("answer mismatch: status exp %0d got %0d, grant exp 0x%0h got 0x%0h",
                             a.status, status, a.grant, grant);
            end
        endfunction

        function int outstanding();
            return pending_answers.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_mode;
    logic [SIZE_W-1:0]  i_size_bytes;
    logic [OFF_W-1:0]   i_release_offset;
    logic               i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CHUNK_W-1:0] i_cfg_data;
    logic               o_valid;
    logic [2:0]         o_status;
    logic [OFF_W-1:0]   o_grant_offset;

    contiguous_chunk_pool_allocator dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_mode           (i_mode),
        .i_size_bytes     (i_size_bytes),
        .i_release_offset (i_release_offset),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_grant_offset   (o_grant_offset)
    );

    alloc_scoreboard sb;
    t_region         live_regions[$];
    int              burst_left;
    longint          cycle_count;

    // The slowest transaction needs two full ring rotations.
    localparam int  ANSWER_LATENCY = 2 * MAX_CHUNKS + 1;
    localparam longint CYCLE_LIMIT = 20_000_000;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: reports a mismatch and stops at CYCLE_LIMIT.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Answers live for one cycle only; sample every edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_answer(o_status, o_grant_offset);
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Holds start until the DUT takes the transaction; start stays high on
    // return so back-to-back transactions need no re-raise.
    task automatic send_cmd(input logic mode, input longint size, input longint off,
                            output t_answer ans);
        i_mode           <= mode;
        i_size_bytes     <= SIZE_W'(size);
        i_release_offset <= OFF_W'(off);
        start            <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        ans = sb.note_accepted(mode, size & 64'h7FF_FFFF, off & 64'h3FF_FFFF);
    endtask

    // Burst/gap pacing on the sender side.
    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end
    endtask

    task automatic issue(input logic mode, input longint size, input longint off);
        t_answer ans;
        send_cmd(mode, size, off, ans);
        if (mode == 1'b0 && ans.status == ST_OK) begin
            t_region r;
            r.offset = ans.grant;
            r.size   = size;
            live_regions.insert(live_regions.size(), r);
        end
        pace();
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // Only called with nothing in flight.
    task automatic write_cfg(input t_cfg_idx idx, input logic [CHUNK_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    // Random phase: mostly alloc/free pairs against live grants, plus noise.
    task automatic run_random(input int count);
        longint  c, p, k, size, off;
        int      pick, sel;
        t_region r;
        c = sb.granule();
        p = sb.pool_len();
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                // allocate a few chunks, size not always chunk aligned
                k = ($urandom_range(0, 9) == 0) ? $urandom_range(1, p) :
                    $urandom_range(1, (p < 6) ? p : 6);
                size = k * c - $urandom_range(0, c - 1);
                issue(1'b0, size, 0);
            end else if (pick < 80 && live_regions.size() != 0) begin
                sel = $urandom_range(0, live_regions.size() - 1);
                r = live_regions[sel];
                live_regions.delete(sel);
                // sometimes release only part, leaving the tail leaked
                size = ($urandom_range(0, 5) == 0) ? $urandom_range(0, r.size) : r.size;
                issue(1'b1, size, r.offset);
            end else begin
                sel = $urandom_range(0, 4);
                case (sel)
                    0: issue(1'($urandom_range(0, 1)), $urandom_range(0, 27'h7FF_FFFF),
                             $urandom_range(0, 26'h3FF_FFFF));
                    1: issue(1'b1, c, $urandom_range(0, p - 1) * c);        // maybe double free
                    2: issue(1'b1, c, $urandom_range(0, p - 1) * c + 1);    // misaligned unless chunk size is 1
                    3: issue(1'b1, $urandom_range(1, 4) * c,
                             (p - $urandom_range(0, 2)) * c);               // at or near the pool end
                    default: issue(1'b0, 0, 0);                             // empty request
                endcase
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        sb = new();
        sb.clear();
        i_rst_n          <= 1'b0;
        start            <= 1'b0;
        i_mode           <= 1'b0;
        i_size_bytes     <= '0;
        i_release_offset <= '0;
        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= CFG_CHUNK_SIZE;
        i_cfg_data       <= '0;
        burst_left       = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset config, 64-byte chunks, full 1024-chunk pool.
        issue(1'b0, 0, 0);                      // zero size allocate
        issue(1'b0, 65536, 0);                  // whole pool
        issue(1'b0, 1, 0);                      // pool full
        issue(1'b1, 65536, 0);                  // give it all back
        issue(1'b1, 64, 0);                     // already free
        issue(1'b1, 64, 65536);                 // offset at pool end
        issue(1'b1, 64, 3);                     // misaligned
        issue(1'b1, 64 * 100, 64 * 1000);       // run past end
        issue(1'b1, 64, 26'h3FF_FFFF);          // max offset
        issue(1'b0, 27'h7FF_FFFF, 0);           // max size
        issue(1'b0, 64 * 1025, 0);              // one chunk too many
        issue(1'b0, 64, 0);
        issue(1'b0, 100, 0);                    // rounds to two chunks
        issue(1'b0, 65, 0);
        issue(1'b1, 0, 0);                      // zero size free, valid offset
        issue(1'b1, 128, 64);                   // free middle run
        issue(1'b0, 128, 0);                    // refills the hole
        issue(1'b1, 256, 0);                    // range fully in use, ends inside a grant
        drain();
        live_regions.delete();

        // Configuration sweep, extremes included.
        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: begin write_cfg(CFG_CHUNK_SIZE, 17'd1);   write_cfg(CFG_POOL_CHUNKS, 17'd1024); end
                1: begin write_cfg(CFG_CHUNK_SIZE, 17'd0);   write_cfg(CFG_POOL_CHUNKS, 17'd16);   end
                2: begin write_cfg(CFG_CHUNK_SIZE, 17'd65536);
                         write_cfg(CFG_POOL_CHUNKS, 17'd1024); end
                3: begin write_cfg(CFG_CHUNK_SIZE, 17'h1FFFF);
                         write_cfg(CFG_POOL_CHUNKS, 17'h007FF); end
                4: begin write_cfg(CFG_CHUNK_SIZE, 17'd3);   write_cfg(CFG_POOL_CHUNKS, 17'd0);    end
                5: begin write_cfg(CFG_CHUNK_SIZE, 17'd100); write_cfg(CFG_POOL_CHUNKS, 17'd1);    end
                6: begin write_cfg(CFG_CHUNK_SIZE, 17'd7);   write_cfg(CFG_POOL_CHUNKS, 17'd37);   end
                7: begin write_cfg(CFG_CHUNK_SIZE, 17'd4096); write_cfg(CFG_POOL_CHUNKS, 17'd8);   end
                8: begin write_cfg(CFG_CHUNK_SIZE, 17'd4096); write_cfg(CFG_POOL_CHUNKS, 17'd64);  end
                default: begin
                    write_cfg(CFG_CHUNK_SIZE, 17'd64);
                    write_cfg(CFG_POOL_CHUNKS, 17'h1F800 | 17'd200);  // upper bits dropped
                end
            endcase
            live_regions.delete();
            run_random(95);
            drain();
        end

        repeat (ANSWER_LATENCY + 50) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
